[rtl/core/cle_pkg.sv]
`timescale 1ns / 1ps
package cle_pkg;

	// line store
	localparam int LINE_DEPTH = 64;
	localparam int AW = $clog2(LINE_DEPTH);

	// front-to-back queue
	localparam int QUEUE_DEPTH = 2;

	// key codes
	localparam logic [7:0] KEY_NONE  = 8'h00;
	localparam logic [7:0] KEY_ENTER = 8'h0A;
	localparam logic [7:0] KEY_BACK  = 8'h08;
	localparam logic [7:0] KEY_LEFT  = 8'h80;
	localparam logic [7:0] KEY_RIGHT = 8'h81;

	localparam logic [7:0] CHAR_SPACE = 8'h20;

	// result actions
	localparam logic [2:0] ACT_ECHO   = 3'd0;
	localparam logic [2:0] ACT_REDRAW = 3'd1;
	localparam logic [2:0] ACT_LEFT   = 3'd2;
	localparam logic [2:0] ACT_RIGHT  = 3'd3;
	localparam logic [2:0] ACT_SUBMIT = 3'd4;

	// command codes
	localparam logic [2:0] CODE_EMPTY   = 3'd0;
	localparam logic [2:0] CODE_UNKNOWN = 3'd6;

	localparam int NUM_WORDS = 5;

	typedef enum logic [2:0] {
		OP_ENTER,
		OP_LEFT,
		OP_RIGHT,
		OP_BACK,
		OP_INSERT
	} op_t;

	typedef struct packed {
		op_t        op;
		logic [7:0] key;
	} item_t;

	// command word lengths: clear, hello, reboot, halt, meminfo
	function automatic logic [2:0] word_len(input logic [2:0] w);
		logic [2:0] len;
		unique case (w)
			3'd0:    len = 3'd5;
			3'd1:    len = 3'd5;
			3'd2:    len = 3'd6;
			3'd3:    len = 3'd4;
			3'd4:    len = 3'd7;
			default: len = 3'd0;
		endcase
		return len;
	endfunction

	// character i of command word w, first character in the low byte
	function automatic logic [7:0] word_char(input logic [2:0] w, input logic [2:0] i);
		logic [63:0] word;
		unique case (w)
			3'd0:    word = 64'h0000_0072_6165_6c63;
			3'd1:    word = 64'h0000_006f_6c6c_6568;
			3'd2:    word = 64'h0000_746f_6f62_6572;
			3'd3:    word = 64'h0000_0000_746c_6168;
			3'd4:    word = 64'h006f_666e_696d_656d;
			default: word = 64'h0;
		endcase
		return word[i*8 +: 8];
	endfunction

endpackage

[rtl/core/cle_ram.sv]
`timescale 1ns / 1ps
module cle_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

[rtl/core/cle_queue.sv]
`timescale 1ns / 1ps
module cle_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  cle_pkg::item_t  push_item,
	output logic            full,
	output logic            pop_valid,
	output cle_pkg::item_t  pop_item,
	input  logic            pop
);

	localparam int PW = $clog2(cle_pkg::QUEUE_DEPTH);
	localparam int CW = $clog2(cle_pkg::QUEUE_DEPTH + 1);

	cle_pkg::item_t entry_q [cle_pkg::QUEUE_DEPTH];
	logic [PW-1:0]  wr_ptr_q;
	logic [PW-1:0]  rd_ptr_q;
	logic [CW-1:0]  fill_q;
	logic           do_push;
	logic           do_pop;

	assign full      = (fill_q == CW'(cle_pkg::QUEUE_DEPTH));
	assign pop_valid = (fill_q != '0);
	assign pop_item  = entry_q[rd_ptr_q];
	assign do_push   = push && !full;
	assign do_pop    = pop && pop_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(cle_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(cle_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				fill_q <= fill_q + 1'b1;
			end else if (do_pop && !do_push) begin
				fill_q <= fill_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_item;
		end
	end

endmodule

[rtl/core/cle_front.sv]
`timescale 1ns / 1ps
module cle_front (
	input  logic            in_valid,
	output logic            in_ready,
	input  logic [7:0]      key,
	input  logic            queue_full,
	output logic            push,
	output cle_pkg::item_t  push_item
);

	// null key is taken and dropped here
	assign in_ready = !queue_full;
	assign push     = in_valid && !queue_full && (key != cle_pkg::KEY_NONE);

	always_comb begin
		push_item.key = key;
		unique case (key)
			cle_pkg::KEY_ENTER: push_item.op = cle_pkg::OP_ENTER;
			cle_pkg::KEY_BACK:  push_item.op = cle_pkg::OP_BACK;
			cle_pkg::KEY_LEFT:  push_item.op = cle_pkg::OP_LEFT;
			cle_pkg::KEY_RIGHT: push_item.op = cle_pkg::OP_RIGHT;
			default:            push_item.op = cle_pkg::OP_INSERT;
		endcase
	end

endmodule

[rtl/core/cle_back.sv]
`timescale 1ns / 1ps
module cle_back (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            q_valid,
	input  cle_pkg::item_t  q_item,
	output logic            q_pop,
	output logic            out_valid,
	input  logic            out_ready,
	output logic [2:0]      action,
	output logic [7:0]      char_value,
	output logic [5:0]      position,
	output logic [5:0]      cursor_now,
	output logic [5:0]      line_length,
	output logic [2:0]      command_code,
	output logic            last
);

	localparam int AW = cle_pkg::AW;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MOVE,
		ST_SH_FETCH,
		ST_SH_WRITE,
		ST_INS_KEY,
		ST_ECHO,
		ST_BK_FETCH,
		ST_BK_WRITE,
		ST_RD_FETCH,
		ST_RD_EMIT,
		ST_SPACE,
		ST_MT_FETCH,
		ST_MT_USE,
		ST_SUBMIT
	} state_t;

	state_t                     state_q;
	logic [AW-1:0]              count_q;
	logic [AW-1:0]              cursor_q;
	logic [AW-1:0]              idx_q;
	logic [7:0]                 key_q;
	logic [2:0]                 move_act_q;
	logic [cle_pkg::NUM_WORDS-1:0] mask_q;
	logic [2:0]                 code_q;

	logic                       out_valid_q;
	logic [2:0]                 action_q;
	logic [7:0]                 char_q;
	logic [AW-1:0]              pos_q;
	logic [AW-1:0]              curn_q;
	logic [AW-1:0]              len_q;
	logic [2:0]                 cmd_q;
	logic                       last_q;

	logic                       slot_free;
	logic                       res_load;
	logic                       ram_we;
	logic [AW-1:0]              ram_waddr;
	logic [7:0]                 ram_wdata;
	logic [7:0]                 ram_rdata;
	logic [cle_pkg::NUM_WORDS-1:0] len_mask;
	logic [cle_pkg::NUM_WORDS-1:0] mask_nx;
	logic [2:0]                 code_nx;

	assign slot_free = !out_valid_q || out_ready;
	assign q_pop     = (state_q == ST_IDLE) && q_valid;

	// a result is loaded into the output register this cycle
	assign res_load  = slot_free && ((state_q == ST_MOVE) || (state_q == ST_ECHO) ||
		(state_q == ST_RD_EMIT) || (state_q == ST_SPACE) || (state_q == ST_SUBMIT));

	// read address follows the index register; the read data is registered in the RAM
	cle_ram #(
		.WIDTH(8),
		.DEPTH(cle_pkg::LINE_DEPTH)
	) u_line_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(idx_q),
		.rdata(ram_rdata)
	);

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = idx_q;
		ram_wdata = ram_rdata;
		unique case (state_q)
			ST_SH_WRITE: begin
				ram_we    = 1'b1;
				ram_waddr = idx_q + 1'b1;
			end
			ST_BK_WRITE: begin
				ram_we    = 1'b1;
				ram_waddr = idx_q - 1'b1;
			end
			ST_INS_KEY: begin
				ram_we    = 1'b1;
				ram_waddr = cursor_q;
				ram_wdata = key_q;
			end
			default: begin
			end
		endcase
	end

	// command word match
	always_comb begin
		logic found;
		found   = 1'b0;
		code_nx = cle_pkg::CODE_UNKNOWN;
		for (int w = 0; w < cle_pkg::NUM_WORDS; w++) begin
			len_mask[w] = (count_q == AW'(cle_pkg::word_len(3'(w))));
			mask_nx[w]  = mask_q[w] &&
				(ram_rdata == cle_pkg::word_char(3'(w), idx_q[2:0]));
		end
		for (int w = 0; w < cle_pkg::NUM_WORDS; w++) begin
			if (mask_nx[w] && !found) begin
				code_nx = 3'(w + 1);
				found   = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			cursor_q    <= '0;
			idx_q       <= '0;
			key_q       <= '0;
			move_act_q  <= cle_pkg::ACT_LEFT;
			mask_q      <= '0;
			code_q      <= cle_pkg::CODE_EMPTY;
			out_valid_q <= 1'b0;
			action_q    <= cle_pkg::ACT_ECHO;
			char_q      <= '0;
			pos_q       <= '0;
			curn_q      <= '0;
			len_q       <= '0;
			cmd_q       <= cle_pkg::CODE_EMPTY;
			last_q      <= 1'b0;
		end else begin
			if (res_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (q_valid) begin
						key_q <= q_item.key;
						unique case (q_item.op)
							cle_pkg::OP_ENTER: begin
								if (count_q == '0) begin
									code_q  <= cle_pkg::CODE_EMPTY;
									state_q <= ST_SUBMIT;
								end else if (len_mask == '0) begin
									code_q  <= cle_pkg::CODE_UNKNOWN;
									state_q <= ST_SUBMIT;
								end else begin
									mask_q  <= len_mask;
									idx_q   <= '0;
									state_q <= ST_MT_FETCH;
								end
							end
							cle_pkg::OP_LEFT: begin
								if (cursor_q != '0) begin
									cursor_q   <= cursor_q - 1'b1;
									move_act_q <= cle_pkg::ACT_LEFT;
									state_q    <= ST_MOVE;
								end
							end
							cle_pkg::OP_RIGHT: begin
								if (cursor_q < count_q) begin
									cursor_q   <= cursor_q + 1'b1;
									move_act_q <= cle_pkg::ACT_RIGHT;
									state_q    <= ST_MOVE;
								end
							end
							cle_pkg::OP_BACK: begin
								if (cursor_q != '0) begin
									cursor_q <= cursor_q - 1'b1;
									count_q  <= count_q - 1'b1;
									if (cursor_q < count_q) begin
										idx_q   <= cursor_q;
										state_q <= ST_BK_FETCH;
									end else begin
										idx_q   <= '0;
										state_q <= (count_q == AW'(1)) ? ST_SPACE : ST_RD_FETCH;
									end
								end
							end
							cle_pkg::OP_INSERT: begin
								if (count_q < AW'(cle_pkg::LINE_DEPTH - 1)) begin
									if (count_q > cursor_q) begin
										idx_q   <= count_q - 1'b1;
										state_q <= ST_SH_FETCH;
									end else begin
										state_q <= ST_INS_KEY;
									end
								end
							end
							default: begin
							end
						endcase
					end
				end
				ST_MOVE: begin
					if (slot_free) begin
						action_q    <= move_act_q;
						char_q      <= '0;
						pos_q       <= cursor_q;
						curn_q      <= cursor_q;
						len_q       <= count_q;
						cmd_q       <= cle_pkg::CODE_EMPTY;
						last_q      <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				ST_SH_FETCH: begin
					state_q <= ST_SH_WRITE;
				end
				ST_SH_WRITE: begin
					if (idx_q == cursor_q) begin
						state_q <= ST_INS_KEY;
					end else begin
						idx_q   <= idx_q - 1'b1;
						state_q <= ST_SH_FETCH;
					end
				end
				ST_INS_KEY: begin
					count_q  <= count_q + 1'b1;
					cursor_q <= cursor_q + 1'b1;
					if (cursor_q == count_q) begin
						state_q <= ST_ECHO;
					end else begin
						idx_q   <= '0;
						state_q <= ST_RD_FETCH;
					end
				end
				ST_ECHO: begin
					if (slot_free) begin
						action_q    <= cle_pkg::ACT_ECHO;
						char_q      <= key_q;
						pos_q       <= cursor_q - 1'b1;
						curn_q      <= cursor_q;
						len_q       <= count_q;
						cmd_q       <= cle_pkg::CODE_EMPTY;
						last_q      <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				ST_BK_FETCH: begin
					state_q <= ST_BK_WRITE;
				end
				ST_BK_WRITE: begin
					if (idx_q == count_q) begin
						idx_q   <= '0;
						state_q <= ST_RD_FETCH;
					end else begin
						idx_q   <= idx_q + 1'b1;
						state_q <= ST_BK_FETCH;
					end
				end
				ST_RD_FETCH: begin
					state_q <= ST_RD_EMIT;
				end
				ST_RD_EMIT: begin
					if (slot_free) begin
						action_q    <= cle_pkg::ACT_REDRAW;
						char_q      <= ram_rdata;
						pos_q       <= idx_q;
						curn_q      <= cursor_q;
						len_q       <= count_q;
						cmd_q       <= cle_pkg::CODE_EMPTY;
						last_q      <= 1'b0;
						if (idx_q == count_q - 1'b1) begin
							state_q <= ST_SPACE;
						end else begin
							idx_q   <= idx_q + 1'b1;
							state_q <= ST_RD_FETCH;
						end
					end
				end
				ST_SPACE: begin
					if (slot_free) begin
						action_q    <= cle_pkg::ACT_REDRAW;
						char_q      <= cle_pkg::CHAR_SPACE;
						pos_q       <= count_q;
						curn_q      <= cursor_q;
						len_q       <= count_q;
						cmd_q       <= cle_pkg::CODE_EMPTY;
						last_q      <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				ST_MT_FETCH: begin
					state_q <= ST_MT_USE;
				end
				ST_MT_USE: begin
					mask_q <= mask_nx;
					if (idx_q == count_q - 1'b1) begin
						code_q  <= code_nx;
						state_q <= ST_SUBMIT;
					end else begin
						idx_q   <= idx_q + 1'b1;
						state_q <= ST_MT_FETCH;
					end
				end
				ST_SUBMIT: begin
					if (slot_free) begin
						action_q    <= cle_pkg::ACT_SUBMIT;
						char_q      <= '0;
						pos_q       <= '0;
						curn_q      <= '0;
						len_q       <= count_q;
						cmd_q       <= code_q;
						last_q      <= 1'b1;
						count_q     <= '0;
						cursor_q    <= '0;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign out_valid    = out_valid_q;
	assign action       = action_q;
	assign char_value   = char_q;
	assign position     = 6'(pos_q);
	assign cursor_now   = 6'(curn_q);
	assign line_length  = 6'(len_q);
	assign command_code = cmd_q;
	assign last         = last_q;

endmodule

[rtl/core/console_line_editor.sv]
`timescale 1ns / 1ps
// Console line editor.
// Input channel: in_valid / in_ready with one key code per item. A front
// stage classifies the key and drops null keys; other keys go into a
// two-entry queue, so in_ready is low only while that queue is full.
// Output channel: out_valid / out_ready, one result per item, fields as
// ports. A key gives zero, one, or a redraw run of line_length + 1 results;
// last marks the final result of each key.
// A cursor move loads its result from the move state; an end-of-line
// insert writes the key and then echoes it. Each character step through
// the line store (shift for an insert or delete, redraw, command compare)
// is a fetch state and then a use state, set by the registered read of
// the single line RAM: a mid-line insert shifts, writes the key and redraws
// the line, a delete shifts any later characters and redraws, and enter
// compares the line against the command words and then submits.
// The back end works on one key at a time and returns to its idle state
// between keys.
// When out_ready is low the result waits in the output register and the
// back end holds; the queue keeps taking keys until it fills.
// Reset (arst_n low) empties the line, puts the cursor at zero and flushes
// the queue and output register. The line RAM is not cleared; only
// entries that were written are ever read.
module console_line_editor (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] key,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [2:0] action,
	output logic [7:0] char_value,
	output logic [5:0] position,
	output logic [5:0] cursor_now,
	output logic [5:0] line_length,
	output logic [2:0] command_code,
	output logic       last
);

	logic           queue_full;
	logic           push;
	cle_pkg::item_t push_item;
	logic           q_valid;
	cle_pkg::item_t q_item;
	logic           q_pop;

	// classify keys
	cle_front u_front (
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.key       (key),
		.queue_full(queue_full),
		.push      (push),
		.push_item (push_item)
	);

	// decouples key intake from the editing engine
	cle_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_item(push_item),
		.full     (queue_full),
		.pop_valid(q_valid),
		.pop_item (q_item),
		.pop      (q_pop)
	);

	// editing engine: line store, cursor, redraw and command match
	cle_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_valid     (q_valid),
		.q_item      (q_item),
		.q_pop       (q_pop),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.action      (action),
		.char_value  (char_value),
		.position    (position),
		.cursor_now  (cursor_now),
		.line_length (line_length),
		.command_code(command_code),
		.last        (last)
	);

	// only redraw runs span several results
	a_single_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (action != cle_pkg::ACT_REDRAW) |-> last)
		else $error("single result without last");

	// command code appears only on a submit
	a_code_submit: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (action != cle_pkg::ACT_SUBMIT) |-> (command_code == cle_pkg::CODE_EMPTY))
		else $error("command code outside submit");

	// cursor stays within the line
	a_cursor_in_line: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (action != cle_pkg::ACT_SUBMIT) |-> (cursor_now <= line_length))
		else $error("cursor past line end");

	// a submit reports the cursor home
	a_submit_home: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (action == cle_pkg::ACT_SUBMIT) |-> (cursor_now == 6'd0) && (position == 6'd0))
		else $error("submit with cursor not home");

endmodule
